// File: src/multigrid_full_weighting_restrict_defines.svh
// Assertion macros for the full weighting restriction block.
// Included by the top level; no other dependencies.
`ifndef MULTIGRID_FULL_WEIGHTING_RESTRICT_DEFINES_SVH
`define MULTIGRID_FULL_WEIGHTING_RESTRICT_DEFINES_SVH

// same-cycle implication
`define MGFWR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MGFWR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/mgfwr_pkg.sv
// Shared types and constants for the full weighting restriction block.
// No dependencies.
package mgfwr_pkg;
	localparam int COARSE_MAX  = 64;
	localparam int SAMPLE_BITS = 32;
	localparam int CRD_W       = $clog2(COARSE_MAX);
	localparam int SIZE_W      = 7;
	localparam int POS_W       = CRD_W + 2;
	localparam int HX_W        = SAMPLE_BITS + 2;
	localparam int HY_W        = SAMPLE_BITS + 4;
	localparam int OUT_W       = SAMPLE_BITS + 6;
	localparam int ZADDR_W     = 2 * CRD_W;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] REG_THREE_D = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NX      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NY      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NZ      = 2'd3;

	typedef enum logic [1:0] {
		CLS_START,
		CLS_ODD,
		CLS_END
	} pos_cls_t;

	typedef struct packed {
		logic signed [HX_W-1:0] hx;
		logic [CRD_W-1:0]       ix;
		logic [CRD_W-1:0]       iy;
		logic [CRD_W-1:0]       iz;
		pos_cls_t               ycls;
		pos_cls_t               zcls;
		logic                   last;
	} event_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [POS_W-1:0] pad_last(input logic [SIZE_W-1:0] n);
		logic [POS_W-1:0] eff;
		if (n == '0)
			eff = POS_W'(1);
		else if (POS_W'(n) > POS_W'(COARSE_MAX))
			eff = POS_W'(COARSE_MAX);
		else
			eff = POS_W'(n);
		return POS_W'(eff << 1);
	endfunction

	function automatic pos_cls_t classify(input logic [POS_W-1:0] p);
		if (p == '0)
			return CLS_START;
		else if (p[0])
			return CLS_ODD;
		else
			return CLS_END;
	endfunction
endpackage

// File: src/mgfwr_front.sv
// Front end: configuration registers, raster position, x filter, event push.
// Depends on mgfwr_pkg.
module mgfwr_front import mgfwr_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [SIZE_W-1:0]             cfg_data,
	input  logic                          accept,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          three_d,
	output logic                          push,
	output event_t                        ev
);
	logic                          three_d_q;
	logic [SIZE_W-1:0]             nx_q, ny_q, nz_q;
	logic [POS_W-1:0]              px_q, py_q, pz_q;
	logic signed [SAMPLE_BITS-1:0] v1_q, v2_q;
	logic [POS_W-1:0]              pxl, pyl, pzl;
	logic [POS_W-2:0]              hpx, hpy, hpz;
	logic                          last;

	assign pxl = pad_last(nx_q);
	assign pyl = pad_last(ny_q);
	assign pzl = three_d_q ? pad_last(nz_q) : '0;
	assign last = (px_q == pxl) && (py_q == pyl) && (pz_q == pzl);

	assign hpx = px_q[POS_W-1:1] - 1'b1;
	assign hpy = py_q[POS_W-1:1] - 1'b1;
	assign hpz = pz_q[POS_W-1:1] - 1'b1;

	always_comb begin
		ev.hx   = HX_W'(v2_q) + (HX_W'(v1_q) <<< 1) + HX_W'(sample);
		ev.ix   = hpx[CRD_W-1:0];
		ev.iy   = hpy[CRD_W-1:0];
		ev.iz   = three_d_q ? hpz[CRD_W-1:0] : '0;
		ev.ycls = classify(py_q);
		ev.zcls = classify(pz_q);
		ev.last = last;
	end

	assign push    = accept && (px_q >= POS_W'(2)) && !px_q[0];
	assign three_d = three_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			three_d_q <= 1'b0;
			nx_q      <= SIZE_W'(COARSE_MAX);
			ny_q      <= SIZE_W'(COARSE_MAX);
			nz_q      <= SIZE_W'(COARSE_MAX);
			px_q      <= '0;
			py_q      <= '0;
			pz_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THREE_D: three_d_q <= cfg_data[0];
				REG_NX:      nx_q <= cfg_data;
				REG_NY:      ny_q <= cfg_data;
				REG_NZ:      nz_q <= cfg_data;
				default:     three_d_q <= three_d_q;
			endcase
			px_q <= '0;
			py_q <= '0;
			pz_q <= '0;
		end else if (accept) begin
			priority if (last) begin
				px_q <= '0;
				py_q <= '0;
				pz_q <= '0;
			end else if (px_q < pxl) begin
				px_q <= px_q + 1'b1;
			end else if (py_q < pyl) begin
				px_q <= '0;
				py_q <= py_q + 1'b1;
			end else begin
				px_q <= '0;
				py_q <= '0;
				pz_q <= pz_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			v1_q <= sample;
			v2_q <= v1_q;
		end
	end
endmodule

// File: src/mgfwr_fifo.sv
// Short event queue between the front end and the back end.
// Depends on mgfwr_pkg.
module mgfwr_fifo import mgfwr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  event_t  din,
	input  logic    pop,
	output event_t  dout,
	output q_stat_t stat
);
	event_t            buf_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign dout       = buf_q[rd_q];
	assign stat.full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_q] <= din;
	end
endmodule

// File: src/mgfwr_back.sv
// Back end: y and z accumulation over line and plane memories, output register.
// Depends on mgfwr_pkg.
module mgfwr_back import mgfwr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    three_d,
	input  logic                    q_empty,
	input  event_t                  head,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [OUT_W-1:0] coarse_value,
	output logic [CRD_W-1:0]        coarse_x,
	output logic [CRD_W-1:0]        coarse_y,
	output logic [CRD_W-1:0]        coarse_z,
	output logic                    grid_done
);
	logic signed [HY_W-1:0]  ymem [COARSE_MAX];
	logic signed [OUT_W-1:0] zmem [COARSE_MAX*COARSE_MAX];

	logic                    adv;
	logic                    v_s1, v_s2, go2;
	event_t                  ev_s1;
	logic signed [HY_W-1:0]  rdy_s1, fy_s1, accy, newy, hy;
	logic                    fwdy_s1;
	logic [CRD_W-1:0]        ix_s2, iy_s2, iz_s2;
	pos_cls_t                zcls_s2;
	logic                    last_s2;
	logic signed [HY_W-1:0]  hy_s2;
	logic signed [OUT_W-1:0] rdz_s2, fz_s2, accz, newz, res;
	logic                    fwdz_s2, emit;
	logic [ZADDR_W-1:0]      za_s1, za_s2;

	logic                    out_valid_q, done_q;
	logic signed [OUT_W-1:0] value_q;
	logic [CRD_W-1:0]        x_q, y_q, z_q;

	assign adv = !out_valid_q || !out_stall;
	assign pop = adv && !q_empty;

	assign accy = fwdy_s1 ? fy_s1 : rdy_s1;
	always_comb begin
		unique case (ev_s1.ycls)
			CLS_START: newy = HY_W'(ev_s1.hx);
			CLS_ODD:   newy = accy + (HY_W'(ev_s1.hx) <<< 1);
			default:   newy = HY_W'(ev_s1.hx);
		endcase
	end
	assign hy  = accy + HY_W'(ev_s1.hx);
	assign go2 = v_s1 && (ev_s1.ycls == CLS_END);
	assign za_s1 = {ev_s1.iy, ev_s1.ix};
	assign za_s2 = {iy_s2, ix_s2};

	assign accz = fwdz_s2 ? fz_s2 : rdz_s2;
	always_comb begin
		unique case (zcls_s2)
			CLS_START: begin
				newz = OUT_W'(hy_s2);
				res  = accz + OUT_W'(hy_s2);
			end
			CLS_ODD: begin
				newz = accz + (OUT_W'(hy_s2) <<< 1);
				res  = accz + OUT_W'(hy_s2);
			end
			default: begin
				newz = OUT_W'(hy_s2);
				res  = accz + OUT_W'(hy_s2);
			end
		endcase
		emit = v_s2 && (!three_d || (zcls_s2 == CLS_END));
		if (!three_d)
			res = OUT_W'(hy_s2) <<< 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= pop;
			v_s2        <= go2;
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ev_s1   <= head;
			rdy_s1  <= ymem[head.ix];
			fwdy_s1 <= v_s1 && (head.ix == ev_s1.ix);
			fy_s1   <= newy;
			if (v_s1)
				ymem[ev_s1.ix] <= newy;

			ix_s2   <= ev_s1.ix;
			iy_s2   <= ev_s1.iy;
			iz_s2   <= ev_s1.iz;
			zcls_s2 <= ev_s1.zcls;
			last_s2 <= ev_s1.last;
			hy_s2   <= hy;
			rdz_s2  <= zmem[za_s1];
			fwdz_s2 <= v_s2 && (za_s1 == za_s2);
			fz_s2   <= newz;
			if (v_s2)
				zmem[za_s2] <= newz;

			value_q <= res;
			x_q     <= ix_s2;
			y_q     <= iy_s2;
			z_q     <= iz_s2;
			done_q  <= last_s2;
		end
	end

	assign out_valid    = out_valid_q;
	assign coarse_value = value_q;
	assign coarse_x     = x_q;
	assign coarse_y     = y_q;
	assign coarse_z     = z_q;
	assign grid_done    = done_q;
endmodule

// File: src/multigrid_full_weighting_restrict.sv
// Top level of the streaming full weighting restriction block.
// Depends on mgfwr_pkg, mgfwr_front, mgfwr_fifo, mgfwr_back and the defines header.
//
//   channel | handshake          | payload
//   in      | in_valid/in_stall  | fine_value
//   out     | out_valid/out_stall| coarse_value, coarse_x/y/z, grid_done
//   cfg     | cfg_we             | cfg_index, cfg_data
//
// One fine sample per unstalled cycle; the x filter works on the accepted sample.
// A result passes the event queue, stages s1 and s2, and the output register.
// The four-entry event queue stalls the input only when full.
// Line and plane memories need no clearing after reset.
`include "multigrid_full_weighting_restrict_defines.svh"
module multigrid_full_weighting_restrict import mgfwr_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [SIZE_W-1:0]             cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] fine_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [OUT_W-1:0]       coarse_value,
	output logic [CRD_W-1:0]              coarse_x,
	output logic [CRD_W-1:0]              coarse_y,
	output logic [CRD_W-1:0]              coarse_z,
	output logic                          grid_done
);
	logic    accept, push, pop, three_d;
	event_t  ev, head;
	q_stat_t q_stat;

	assign in_stall = q_stat.full;
	assign accept   = in_valid && !in_stall;

	mgfwr_front u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.accept(accept), .sample(fine_value),
		.three_d(three_d), .push(push), .ev(ev)
	);

	mgfwr_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .din(ev), .pop(pop), .dout(head), .stat(q_stat)
	);

	mgfwr_back u_back (
		.clk(clk), .arst_n(arst_n), .three_d(three_d),
		.q_empty(q_stat.empty), .head(head), .pop(pop),
		.out_valid(out_valid), .out_stall(out_stall),
		.coarse_value(coarse_value), .coarse_x(coarse_x), .coarse_y(coarse_y),
		.coarse_z(coarse_z), .grid_done(grid_done)
	);

	`MGFWR_ASSERT_NOW(a_no_push_full, clk, arst_n, push, !q_stat.full, "push into full queue")
	`MGFWR_ASSERT_NOW(a_no_pop_empty, clk, arst_n, pop, !q_stat.empty, "pop from empty queue")
	`MGFWR_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid, "valid dropped")
endmodule
